// ----- design/assert_macros.svh -----
// Assertion macros shared by the key cache modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, expr) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- design/flkc_pkg.sv -----
// Shared types and constants of the key cache.
`default_nettype none

package flkc_pkg;

	localparam int CNT_W      = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [1:0] CMD_SEARCH = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 1'b1;

	localparam logic [CFG_DATA_W-1:0] CAP_RESET = 5'd16;
	localparam logic MODE_FIFO = 1'b0;
	localparam logic MODE_LRU  = 1'b1;

	// Operation handed to the entry array for one transaction.
	typedef struct packed {
		logic       go;
		logic [1:0] cmd;
		logic       read_only;
		logic       lru;
	} op_t;

	// Lookup outcome reported back by the entry array.
	typedef struct packed {
		logic hit;
		logic evict;
		logic alloc;
	} look_t;

endpackage

`default_nettype wire

// ----- design/fifo_lru_key_cache.sv -----
// Fully associative key cache with FIFO or LRU replacement. Each transaction
// is registered at the input, then a single pass of parallel key compare
// across all entries, age rank update and payload memory access produces the
// result, which is held in an output register. Throughput is one transaction
// every cycle while the output side keeps taking results. The payload memory
// has one write and one registered read port; the read port is used once per
// transaction, the write port only by inserts. Configuration is to be written
// through cfg_we/cfg_index/cfg_data only while no transaction is in flight;
// the block itself does not enforce this.
`default_nettype none
`include "assert_macros.svh"

module fifo_lru_key_cache #(
	parameter int ENTRY_COUNT = 16,
	parameter int KEY_BITS    = 31,
	parameter int DATA_BITS   = 32,
	localparam int IDX_W      = $clog2(ENTRY_COUNT),
	localparam int OCC_W      = $clog2(ENTRY_COUNT + 1),
	localparam int IN_RAW     = KEY_BITS + DATA_BITS,
	localparam int IN_W       = ((IN_RAW + 7) / 8) * 8,
	localparam int OUT_RAW    = DATA_BITS + KEY_BITS + OCC_W + 2 * flkc_pkg::CNT_W,
	localparam int OUT_W      = ((OUT_RAW + 7) / 8) * 8
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire  [flkc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [flkc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire  [IN_W-1:0]                   s_tdata,  // key_id, entry_data
	input  wire  [2:0]                        s_tuser,  // cmd, read_only
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// data_out, evicted_key, occupancy, hit_count, miss_count
	output logic [OUT_W-1:0]                  m_tdata,
	output logic [1:0]                        m_tuser   // found, evicted
);

	localparam int CMP_W = (OCC_W > flkc_pkg::CFG_DATA_W) ? OCC_W : flkc_pkg::CFG_DATA_W;

	logic [flkc_pkg::CFG_DATA_W-1:0] cap_q;
	logic                            mode_q;
	logic [CMP_W-1:0]                cap_ext;
	logic [OCC_W-1:0]                eff_cap;

	logic                 valid_s1;
	logic [1:0]           cmd_s1;
	logic [KEY_BITS-1:0]  key_s1;
	logic [DATA_BITS-1:0] data_s1;
	logic                 ro_s1;
	logic                 advance;

	logic                 valid_s2;
	logic                 found_s2;
	logic                 sel_s2;
	logic                 evicted_s2;
	logic [KEY_BITS-1:0]  evkey_s2;
	logic [DATA_BITS-1:0] pay_rd_s2;
	logic [DATA_BITS-1:0] data_out;

	logic [flkc_pkg::CNT_W-1:0] hits_q;
	logic [flkc_pkg::CNT_W-1:0] misses_q;

	logic [DATA_BITS-1:0] pay_mem [ENTRY_COUNT];
	logic                 pay_we;
	logic [IDX_W-1:0]     pay_waddr;

	flkc_pkg::op_t        op;
	flkc_pkg::look_t      look;
	logic [IDX_W-1:0]     hit_idx;
	logic [IDX_W-1:0]     alloc_idx;
	logic [KEY_BITS-1:0]  evict_key;
	logic [OCC_W-1:0]     used;
	logic                 is_search;
	logic                 is_ins;
	logic                 is_rem;
	logic                 count_hit;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= flkc_pkg::CAP_RESET;
			mode_q <= flkc_pkg::MODE_FIFO;
		end else if (cfg_we) begin
			case (cfg_index)
				flkc_pkg::REG_CAPACITY: cap_q <= cfg_data;
				flkc_pkg::REG_MODE:     mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// A capacity of zero acts as one, and one above the entry count is clipped.
	always_comb begin
		cap_ext = CMP_W'(cap_q);
		if (cap_q == '0) begin
			eff_cap = OCC_W'(1);
		end else if (cap_ext > CMP_W'(ENTRY_COUNT)) begin
			eff_cap = OCC_W'(ENTRY_COUNT);
		end else begin
			eff_cap = cap_ext[OCC_W-1:0];
		end
	end

	// Input register.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser[1:0];
			ro_s1   <= s_tuser[2];
			key_s1  <= s_tdata[KEY_BITS-1:0];
			data_s1 <= s_tdata[IN_RAW-1:KEY_BITS];
		end
	end

	// Single pass over the entry array.
	assign is_search = (cmd_s1 == flkc_pkg::CMD_SEARCH);
	assign is_ins    = (cmd_s1 == flkc_pkg::CMD_INSERT);
	assign is_rem    = (cmd_s1 == flkc_pkg::CMD_REMOVE);

	always_comb begin
		op.go        = advance;
		op.cmd       = cmd_s1;
		op.read_only = ro_s1;
		op.lru       = (mode_q == flkc_pkg::MODE_LRU);
	end

	flkc_entries #(
		.ENTRY_COUNT (ENTRY_COUNT),
		.KEY_BITS    (KEY_BITS)
	) u_entries (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.key_in    (key_s1),
		.eff_cap   (eff_cap),
		.look      (look),
		.hit_idx   (hit_idx),
		.alloc_idx (alloc_idx),
		.evict_key (evict_key),
		.used      (used)
	);

	assign count_hit = is_search && look.hit && !ro_s1;

	// Payload memory: an insert of a present key rewrites its slot in place.
	assign pay_we    = advance && is_ins && (look.hit || look.alloc);
	assign pay_waddr = look.hit ? hit_idx : alloc_idx;

	always_ff @(posedge clk) begin
		if (pay_we) begin
			pay_mem[pay_waddr] <= data_s1;
		end
		if (advance) begin
			pay_rd_s2 <= pay_mem[hit_idx];
		end
	end

	// Saturating counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q   <= '0;
			misses_q <= '0;
		end else if (advance) begin
			if (count_hit && (hits_q != '1)) begin
				hits_q <= hits_q + flkc_pkg::CNT_W'(1);
			end
			if (is_ins && (misses_q != '1)) begin
				misses_q <= misses_q + flkc_pkg::CNT_W'(1);
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			found_s2   <= look.hit && (is_search || is_ins || is_rem);
			sel_s2     <= is_search && look.hit;
			evicted_s2 <= look.evict;
			evkey_s2   <= look.evict ? evict_key : '0;
		end
	end

	// Occupancy and counters only change when a transaction leaves the input
	// register, so their current values belong to the result being shown.
	assign data_out = sel_s2 ? pay_rd_s2 : '0;
	assign m_tvalid = valid_s2;
	assign m_tuser  = {evicted_s2, found_s2};
	assign m_tdata  = OUT_W'({misses_q, hits_q, used, evkey_s2, data_out});

	`ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(key_s1))
	`ASSERT_NEXT(a_insert_counted, clk, arst_n, advance && is_ins, misses_q != '0)
	`ASSERT_NEXT(a_hit_counted, clk, arst_n, advance && count_hit, hits_q != '0)

endmodule

`default_nettype wire

// ----- design/flkc_entries.sv -----
// Key match array with valid bits, age ranks and the occupancy count.
`default_nettype none
`include "assert_macros.svh"

module flkc_entries #(
	parameter int ENTRY_COUNT = 16,
	parameter int KEY_BITS    = 31,
	localparam int IDX_W      = $clog2(ENTRY_COUNT),
	localparam int OCC_W      = $clog2(ENTRY_COUNT + 1)
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire  flkc_pkg::op_t     op,
	input  wire  [KEY_BITS-1:0]     key_in,
	input  wire  [OCC_W-1:0]        eff_cap,
	output flkc_pkg::look_t         look,
	output logic [IDX_W-1:0]        hit_idx,
	output logic [IDX_W-1:0]        alloc_idx,
	output logic [KEY_BITS-1:0]     evict_key,
	output logic [OCC_W-1:0]        used
);

	logic [ENTRY_COUNT-1:0] valid_q;
	logic [IDX_W-1:0]       rank_q [ENTRY_COUNT];
	logic [KEY_BITS-1:0]    key_q  [ENTRY_COUNT];
	logic [OCC_W-1:0]       used_q;

	logic [ENTRY_COUNT-1:0] hit_vec;
	logic [ENTRY_COUNT-1:0] old_vec;
	logic [ENTRY_COUNT-1:0] free_vec;
	logic [ENTRY_COUNT-1:0] alloc_oh;
	logic [IDX_W-1:0]       hit_rank;
	logic [IDX_W-1:0]       gap_rank;
	logic [IDX_W-1:0]       newest_rank;
	logic [IDX_W-1:0]       alloc_rank;
	logic [OCC_W-1:0]       used_m1;
	logic [OCC_W-1:0]       used_after_evict;
	logic [OCC_W-1:0]       used_next;
	logic                   is_search;
	logic                   is_ins;
	logic                   is_rem;
	logic                   hit;
	logic                   full;
	logic                   evict;
	logic                   alloc;
	logic                   touch;
	logic                   rem_hit;
	logic                   gap_en;

	always_comb begin
		hit_rank  = '0;
		evict_key = '0;
		hit_idx   = '0;
		alloc_idx = '0;
		for (int j = 0; j < ENTRY_COUNT; j++) begin
			hit_vec[j] = valid_q[j] && (key_q[j] == key_in);
			old_vec[j] = valid_q[j] && (rank_q[j] == '0);
		end
		for (int j = 0; j < ENTRY_COUNT; j++) begin
			if (hit_vec[j]) begin
				hit_rank = hit_rank | rank_q[j];
				hit_idx  = hit_idx | IDX_W'(j);
			end
			if (old_vec[j]) begin
				evict_key = evict_key | key_q[j];
			end
		end

		is_search = (op.cmd == flkc_pkg::CMD_SEARCH);
		is_ins    = (op.cmd == flkc_pkg::CMD_INSERT);
		is_rem    = (op.cmd == flkc_pkg::CMD_REMOVE);
		hit       = |hit_vec;
		full      = (used_q >= eff_cap);
		evict     = is_ins && !hit && full && (|old_vec);

		// The evicted slot is free again for the new key in the same pass.
		free_vec  = ~valid_q | (evict ? old_vec : '0);
		alloc_oh  = free_vec & (~free_vec + ENTRY_COUNT'(1));
		alloc     = is_ins && !hit && (|free_vec);
		for (int j = 0; j < ENTRY_COUNT; j++) begin
			if (alloc_oh[j]) begin
				alloc_idx = alloc_idx | IDX_W'(j);
			end
		end

		touch   = op.lru && hit && ((is_search && !op.read_only) || is_ins);
		rem_hit = is_rem && hit;
		gap_en  = touch || rem_hit || evict;
		gap_rank = evict ? '0 : hit_rank;

		used_m1          = used_q - OCC_W'(1);
		newest_rank      = used_m1[IDX_W-1:0];
		used_after_evict = used_q - OCC_W'(evict);
		alloc_rank       = used_after_evict[IDX_W-1:0];
		used_next        = used_after_evict - OCC_W'(rem_hit) + OCC_W'(alloc);

		look.hit   = hit;
		look.evict = evict;
		look.alloc = alloc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
			for (int j = 0; j < ENTRY_COUNT; j++) begin
				rank_q[j] <= '0;
			end
		end else if (op.go) begin
			used_q <= used_next;
			for (int j = 0; j < ENTRY_COUNT; j++) begin
				if (alloc && alloc_oh[j]) begin
					valid_q[j] <= 1'b1;
					rank_q[j]  <= alloc_rank;
				end else if (touch && hit_vec[j]) begin
					rank_q[j] <= newest_rank;
				end else if ((rem_hit && hit_vec[j]) || (evict && old_vec[j])) begin
					valid_q[j] <= 1'b0;
					rank_q[j]  <= '0;
				end else if (gap_en && valid_q[j] && (rank_q[j] > gap_rank)) begin
					// Entries younger than the one leaving its place move down one rank.
					rank_q[j] <= rank_q[j] - IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < ENTRY_COUNT; j++) begin
			if (op.go && alloc && alloc_oh[j]) begin
				key_q[j] <= key_in;
			end
		end
	end

	assign used = used_q;

	`ASSERT_ALWAYS(a_key_unique, clk, arst_n, $onehot0(hit_vec))
	`ASSERT_ALWAYS(a_used_matches_valid, clk, arst_n, $countones(valid_q) == used_q)
	`ASSERT_IMPL(a_evict_refills, clk, arst_n, op.go && evict, alloc)

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking testbench of the fully associative key cache with FIFO or LRU replacement.
`timescale 1ns / 1ps

module tb;

	localparam int ENTRIES      = 16;
	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 80;
	localparam int SETTLE       = 6;
	localparam int POOL_SIZE    = 24;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Bit positions of the result fields in m_tdata.
	localparam int DOUT_LSB = 0;
	localparam int EKEY_LSB = 32;
	localparam int OCC_LSB  = 63;
	localparam int HITS_LSB = 68;
	localparam int MISS_LSB = 100;

	typedef struct packed {
		logic        found;
		logic [31:0] data_out;
		logic        evicted;
		logic [30:0] evicted_key;
		logic [4:0]  occupancy;
		logic [31:0] hit_count;
		logic [31:0] miss_count;
	} cache_result_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [0:0]   cfg_index;
	logic [4:0]   cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [63:0]  s_tdata;
	logic [2:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [135:0] m_tdata;
	logic [1:0]   m_tuser;

	fifo_lru_key_cache u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// Shadow copy of the cache contents and configuration.
	logic [30:0] shadow_key   [ENTRIES];
	logic [31:0] shadow_data  [ENTRIES];
	logic        shadow_valid [ENTRIES];
	logic [4:0]  shadow_rank  [ENTRIES];
	logic [4:0]  shadow_used;
	logic [31:0] shadow_hits;
	logic [31:0] shadow_misses;
	logic [4:0]  shadow_cap;
	logic        shadow_mode;

	cache_result_t pending_results[$];
	logic [30:0]   key_pool[POOL_SIZE];

	int  error_count;
	int  idle_cycles;
	bit  quiet;
	int  hold_asked;
	int  hold_granted;
	int  hold_left;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic shadow_reset();
		for (int i = 0; i < ENTRIES; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_rank[i]  = '0;
			shadow_key[i]   = '0;
			shadow_data[i]  = '0;
		end
		shadow_used   = '0;
		shadow_hits   = '0;
		shadow_misses = '0;
		shadow_cap    = flkc_pkg::CAP_RESET;
		shadow_mode   = flkc_pkg::MODE_FIFO;
	endtask

	// Every valid entry younger than entry idx moves down one rank.
	task automatic close_rank_gap(input int idx);
		for (int j = 0; j < ENTRIES; j++) begin
			if (j != idx && shadow_valid[j] && shadow_rank[j] > shadow_rank[idx])
				shadow_rank[j] = shadow_rank[j] - 5'd1;
		end
	endtask

	task automatic make_newest(input int idx);
		close_rank_gap(idx);
		shadow_rank[idx] = (shadow_used > 0) ? shadow_used - 5'd1 : 5'd0;
	endtask

	task automatic predict_cache(input logic [1:0] cmd, input logic [30:0] key,
			input logic [31:0] data, input logic ro, output cache_result_t r);
		int  hit_idx;
		int  cap_eff;
		bit  placed;
		bit  dropped;
		hit_idx = -1;
		placed  = 0;
		dropped = 0;
		r = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit_idx < 0 && shadow_valid[i] && shadow_key[i] == key)
				hit_idx = i;
		end
		cap_eff = (shadow_cap == 0) ? 1 : ((shadow_cap > ENTRIES) ? ENTRIES : shadow_cap);
		case (cmd)
			flkc_pkg::CMD_SEARCH: begin
				if (hit_idx >= 0) begin
					r.found    = 1'b1;
					r.data_out = shadow_data[hit_idx];
					if (!ro) begin
						if (shadow_hits != '1)
							shadow_hits = shadow_hits + 32'd1;
						if (shadow_mode == flkc_pkg::MODE_LRU)
							make_newest(hit_idx);
					end
				end
			end
			flkc_pkg::CMD_INSERT: begin
				if (shadow_misses != '1)
					shadow_misses = shadow_misses + 32'd1;
				if (hit_idx >= 0) begin
					r.found = 1'b1;
					shadow_data[hit_idx] = data;
					if (shadow_mode == flkc_pkg::MODE_LRU)
						make_newest(hit_idx);
				end else begin
					if (shadow_used >= cap_eff) begin
						for (int i = 0; i < ENTRIES; i++) begin
							if (!dropped && shadow_valid[i] && shadow_rank[i] == 0) begin
								dropped = 1;
								r.evicted     = 1'b1;
								r.evicted_key = shadow_key[i];
								close_rank_gap(i);
								shadow_valid[i] = 1'b0;
								shadow_rank[i]  = '0;
								if (shadow_used > 0)
									shadow_used = shadow_used - 5'd1;
							end
						end
					end
					for (int i = 0; i < ENTRIES; i++) begin
						if (!placed && !shadow_valid[i]) begin
							placed = 1;
							shadow_valid[i] = 1'b1;
							shadow_key[i]   = key;
							shadow_data[i]  = data;
							shadow_rank[i]  = shadow_used;
							shadow_used     = shadow_used + 5'd1;
						end
					end
				end
			end
			flkc_pkg::CMD_REMOVE: begin
				if (hit_idx >= 0) begin
					r.found = 1'b1;
					close_rank_gap(hit_idx);
					shadow_valid[hit_idx] = 1'b0;
					shadow_rank[hit_idx]  = '0;
					if (shadow_used > 0)
						shadow_used = shadow_used - 5'd1;
				end
			end
			default: ;
		endcase
		r.occupancy  = shadow_used;
		r.hit_count  = shadow_hits;
		r.miss_count = shadow_misses;
	endtask

	// Entered and left at a falling edge.
	task automatic send_op(input logic [1:0] cmd, input logic [30:0] key,
			input logic [31:0] data, input logic ro);
		cache_result_t r;
		if (!quiet && $urandom_range(99) < 35) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, data, key};
		s_tuser  <= {ro, cmd};
		do @(posedge clk); while (!s_tready);
		predict_cache(cmd, key, data, ro, r);
		pending_results.push_back(r);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Written only while the cache is idle.
	task automatic set_config(input logic [4:0] cap, input logic mode);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= flkc_pkg::REG_CAPACITY;
		cfg_data  <= cap;
		@(negedge clk);
		cfg_index <= flkc_pkg::REG_MODE;
		cfg_data  <= {4'd0, mode};
		@(negedge clk);
		cfg_we    <= 1'b0;
		shadow_cap  = cap;
		shadow_mode = mode;
		@(negedge clk);
	endtask

	task automatic refill_key_pool();
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = 31'($urandom());
	endtask

	task automatic send_random_op();
		int          pick;
		logic [1:0]  cmd;
		logic [30:0] key;
		pick = $urandom_range(99);
		if (pick < 40)
			cmd = flkc_pkg::CMD_SEARCH;
		else if (pick < 75)
			cmd = flkc_pkg::CMD_INSERT;
		else if (pick < 95)
			cmd = flkc_pkg::CMD_REMOVE;
		else
			cmd = CMD_UNUSED;
		if ($urandom_range(9) == 0)
			key = 31'($urandom());
		else
			key = key_pool[$urandom_range(POOL_SIZE - 1)];
		send_op(cmd, key, $urandom(), 1'($urandom_range(1)));
	endtask

	task automatic test_basic_ops();
		send_op(flkc_pkg::CMD_SEARCH, 31'd0, 32'hDEAD_BEEF, 1'b0);
		send_op(flkc_pkg::CMD_INSERT, 31'd0, 32'hFFFF_FFFF, 1'b0);
		send_op(flkc_pkg::CMD_INSERT, 31'h7FFF_FFFF, 32'h0000_0000, 1'b0);
		send_op(flkc_pkg::CMD_SEARCH, 31'd0, 32'h0, 1'b1);
		send_op(flkc_pkg::CMD_SEARCH, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		// Re-inserting a present key replaces its payload in place.
		send_op(flkc_pkg::CMD_INSERT, 31'd0, 32'h1234_5678, 1'b0);
		send_op(flkc_pkg::CMD_SEARCH, 31'd0, 32'h0, 1'b0);
		send_op(flkc_pkg::CMD_REMOVE, 31'h0000_0055, 32'h0, 1'b0);
		send_op(flkc_pkg::CMD_REMOVE, 31'h7FFF_FFFF, 32'h0, 1'b1);
		send_op(CMD_UNUSED, 31'd0, 32'hFFFF_FFFF, 1'b1);
		send_op(flkc_pkg::CMD_INSERT, 31'h2AAA_AAAA, 32'hAAAA_AAAA, 1'b1);
		send_op(flkc_pkg::CMD_SEARCH, 31'h2AAA_AAAA, 32'h5555_5555, 1'b1);
	endtask

	task automatic test_fifo_capacity();
		set_config(5'd3, flkc_pkg::MODE_FIFO);
		for (int i = 1; i <= 5; i++)
			send_op(flkc_pkg::CMD_INSERT, 31'(i * 17), $urandom(), 1'b0);
		// Under FIFO a re-inserted key keeps its place in the order.
		send_op(flkc_pkg::CMD_INSERT, 31'(3 * 17), 32'h0BAD_F00D, 1'b0);
		send_op(flkc_pkg::CMD_INSERT, 31'd999, $urandom(), 1'b0);
		// A capacity of zero behaves as one.
		set_config(5'd0, flkc_pkg::MODE_FIFO);
		send_op(flkc_pkg::CMD_INSERT, 31'd1000, $urandom(), 1'b0);
		send_op(flkc_pkg::CMD_INSERT, 31'd1001, $urandom(), 1'b0);
		// Capacity above the entry count behaves as the full array.
		set_config(5'd31, flkc_pkg::MODE_FIFO);
		for (int i = 0; i < ENTRIES + 3; i++)
			send_op(flkc_pkg::CMD_INSERT, 31'(2000 + i), $urandom(), 1'b0);
		// Lowered below occupancy: each new key evicts just one entry.
		set_config(5'd2, flkc_pkg::MODE_FIFO);
		send_op(flkc_pkg::CMD_INSERT, 31'd3000, $urandom(), 1'b0);
		send_op(flkc_pkg::CMD_INSERT, 31'd3001, $urandom(), 1'b0);
		send_op(flkc_pkg::CMD_SEARCH, 31'd3000, 32'h0, 1'b0);
	endtask

	task automatic test_lru_order();
		set_config(5'd16, flkc_pkg::MODE_LRU);
		for (int i = 0; i < ENTRIES; i++)
			send_op(flkc_pkg::CMD_REMOVE, 31'(2000 + i), 32'h0, 1'b0);
		send_op(flkc_pkg::CMD_REMOVE, 31'd3000, 32'h0, 1'b0);
		send_op(flkc_pkg::CMD_REMOVE, 31'd3001, 32'h0, 1'b0);
		set_config(5'd1, flkc_pkg::MODE_LRU);
		send_op(flkc_pkg::CMD_INSERT, 31'd40, 32'h40, 1'b0);
		send_op(flkc_pkg::CMD_INSERT, 31'd41, 32'h41, 1'b0);
		set_config(5'd3, flkc_pkg::MODE_LRU);
		send_op(flkc_pkg::CMD_INSERT, 31'd42, 32'h42, 1'b0);
		send_op(flkc_pkg::CMD_INSERT, 31'd43, 32'h43, 1'b0);
		send_op(flkc_pkg::CMD_SEARCH, 31'd41, 32'h0, 1'b0);
		send_op(flkc_pkg::CMD_SEARCH, 31'd42, 32'h0, 1'b1);
		send_op(flkc_pkg::CMD_INSERT, 31'd44, 32'h44, 1'b0);
		send_op(flkc_pkg::CMD_INSERT, 31'd41, 32'h4141, 1'b0);
		send_op(flkc_pkg::CMD_INSERT, 31'd45, 32'h45, 1'b0);
		send_op(flkc_pkg::CMD_REMOVE, 31'd44, 32'h0, 1'b0);
		send_op(flkc_pkg::CMD_INSERT, 31'd46, 32'h46, 1'b0);
	endtask

	task automatic test_random_mix();
		logic [4:0] caps  [6] = '{5'd16, 5'd4, 5'd1, 5'd31, 5'd0, 5'd8};
		logic       modes [6] = '{flkc_pkg::MODE_FIFO, flkc_pkg::MODE_LRU,
			flkc_pkg::MODE_FIFO, flkc_pkg::MODE_LRU, flkc_pkg::MODE_LRU,
			flkc_pkg::MODE_FIFO};
		for (int p = 0; p < 6; p++) begin
			set_config(caps[p], modes[p]);
			refill_key_pool();
			quiet = (p == 3);
			repeat (130) send_random_op();
			quiet = 0;
		end
	endtask

	// The receiver holds off while the sender keeps offering, so the input stalls.
	task automatic test_backpressure();
		set_config(5'd6, flkc_pkg::MODE_LRU);
		refill_key_pool();
		quiet = 1;
		hold_asked = hold_asked + 1;
		repeat (40) send_random_op();
		quiet = 0;
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_granted != hold_asked) begin
			hold_granted = hold_asked;
			hold_left = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet || ($urandom_range(99) >= 35);
		end
	end

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			error_count = error_count + 1;
		end
	endtask

	always @(posedge clk) begin
		cache_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result transaction, actual %h %h",
					$time, m_tuser, m_tdata);
				error_count = error_count + 1;
			end else begin
				exp_r = pending_results.pop_front();
				check_field("found", exp_r.found, m_tuser[0]);
				check_field("evicted", exp_r.evicted, m_tuser[1]);
				check_field("data_out", exp_r.data_out, m_tdata[DOUT_LSB +: 32]);
				check_field("evicted_key", exp_r.evicted_key, m_tdata[EKEY_LSB +: 31]);
				check_field("occupancy", exp_r.occupancy, m_tdata[OCC_LSB +: 5]);
				check_field("hit_count", exp_r.hit_count, m_tdata[HITS_LSB +: 32]);
				check_field("miss_count", exp_r.miss_count, m_tdata[MISS_LSB +: 32]);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = flkc_pkg::REG_CAPACITY;
		cfg_data     = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		m_tready     = 1'b0;
		error_count  = 0;
		idle_cycles  = 0;
		quiet        = 0;
		hold_asked   = 0;
		hold_granted = 0;
		hold_left    = 0;
		shadow_reset();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_basic_ops();
		test_fifo_capacity();
		test_lru_order();
		test_random_mix();
		test_backpressure();
		drain();
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+design
design/flkc_pkg.sv
design/flkc_entries.sv
design/fifo_lru_key_cache.sv
bench/tb.sv
